// ----- rtl/core/vhd_pkg.sv -----
// ----------------------------------------------------------------------------
// vhd_pkg
// shared constants, types and the trellis branch function of the hard decision decoder
// ----------------------------------------------------------------------------
package vhd_pkg;

   localparam int STATE_BITS  = 6;
   localparam int NSTATES     = 1 << STATE_BITS;
   localparam int PAIR_W      = STATE_BITS - 1;
   localparam int TB_DEPTH    = 32;
   localparam int HCOLS       = TB_DEPTH + 1;
   localparam int COL_W       = $clog2(HCOLS);
   localparam int K_W         = $clog2(TB_DEPTH + 1);
   localparam int METRIC_BITS = 16;
   localparam int POLY_W      = 7;
   localparam int LIMIT_W     = 15;
   localparam int BEST_W      = 15;
   localparam int STEP_W      = 16;
   localparam int CNT_W       = STATE_BITS + 1;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int SURV_DEPTH  = HCOLS * NSTATES;
   localparam int MET_DEPTH   = NSTATES;
   localparam int MET_W       = 2 * METRIC_BITS;

   localparam logic [METRIC_BITS-1:0] METRIC_MAX = {METRIC_BITS{1'b1}};
   localparam logic [BEST_W-1:0]      BEST_MAX   = {BEST_W{1'b1}};
   localparam logic [STEP_W-1:0]      STEP_MAX   = {STEP_W{1'b1}};

   localparam logic [POLY_W-1:0]  POLY_A_RESET = POLY_W'(121);
   localparam logic [POLY_W-1:0]  POLY_B_RESET = POLY_W'(91);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(16384);

   localparam logic [CSR_IDX_W-1:0] CSR_GEN_POLY_A   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GEN_POLY_B   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_LIMIT = 2'd2;

   typedef struct packed {
      logic                   fresh;
      logic                   norm;
      logic [METRIC_BITS-1:0] norm_x;
      logic [LIMIT_W-1:0]     norm_lim;
      logic                   tail;
      logic                   rx_a;
      logic                   rx_b;
      logic [POLY_W-1:0]      poly_a;
      logic [POLY_W-1:0]      poly_b;
   } acs_ctrl_type;

   typedef struct packed {
      logic [METRIC_BITS-1:0] metric;
      logic [STATE_BITS-1:0]  survivor;
   } acs_result_type;

   function automatic logic [1:0] branch_code(input logic [STATE_BITS-1:0] st,
                                              input logic bit_in,
                                              input logic [POLY_W-1:0] pa,
                                              input logic [POLY_W-1:0] pb);
      logic [POLY_W-1:0] shreg;
      shreg    = '0;
      shreg[0] = bit_in;
      for (int i = 1; i <= STATE_BITS; i++) shreg[i] = st[STATE_BITS-i];
      return {^(shreg & pa), ^(shreg & pb)};
   endfunction

endpackage

// ----- rtl/core/vhd_if.sv -----
// ----------------------------------------------------------------------------
// vhd channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface vhd_req_if;
   logic valid;
   logic ready;
   logic rx_bit_a;
   logic rx_bit_b;
   logic frame_start;
   logic is_tail;
   logic frame_last;
   modport source(output valid, rx_bit_a, rx_bit_b, frame_start, is_tail, frame_last,
                  input ready);
   modport sink(input valid, rx_bit_a, rx_bit_b, frame_start, is_tail, frame_last,
                output ready);
endinterface

interface vhd_rsp_if;
   import vhd_pkg::*;
   logic              valid;
   logic              ready;
   logic              decoded_bit;
   logic              last_of_frame;
   logic [BEST_W-1:0] best_metric;
   modport source(output valid, decoded_bit, last_of_frame, best_metric, input ready);
   modport sink(input valid, decoded_bit, last_of_frame, best_metric, output ready);
endinterface

interface vhd_csr_if;
   import vhd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/vhd_ram.sv -----
// ----------------------------------------------------------------------------
// vhd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module vhd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- rtl/core/vhd_acs.sv -----
// ----------------------------------------------------------------------------
// vhd_acs
// shared add-compare-select unit, one trellis state per cycle
// ----------------------------------------------------------------------------
module vhd_acs (
   input  logic [vhd_pkg::STATE_BITS-1:0] state_n,
   input  logic [vhd_pkg::MET_W-1:0]      pair_word,
   input  vhd_pkg::acs_ctrl_type          ctrl,
   output vhd_pkg::acs_result_type        result
);
   import vhd_pkg::*;

   logic [STATE_BITS-1:0]  p0, p1;
   logic                   bit_n;
   logic [METRIC_BITS-1:0] raw0, raw1, m0, m1, lim_w;
   logic [1:0]             k0, k1;
   logic [METRIC_BITS:0]   s0, s1;
   logic [METRIC_BITS-1:0] c0, c1;

   function automatic logic [METRIC_BITS-1:0] prep(input logic [METRIC_BITS-1:0] raw,
                                                   input logic is_zero,
                                                   input acs_ctrl_type c,
                                                   input logic [METRIC_BITS-1:0] lim);
      logic [METRIC_BITS-1:0] d;
      d = raw - c.norm_x;
      if (c.fresh) return is_zero ? '0 : METRIC_MAX;
      else if (c.norm) return (d > lim) ? lim : d;
      else return raw;
   endfunction

   always_comb begin
      bit_n = state_n[STATE_BITS-1];
      p0    = {state_n[STATE_BITS-2:0], 1'b0};
      p1    = {state_n[STATE_BITS-2:0], 1'b1};
      lim_w = METRIC_BITS'(ctrl.norm_lim);
      raw0  = pair_word[METRIC_BITS-1:0];
      raw1  = pair_word[MET_W-1:METRIC_BITS];
      m0    = prep(raw0, (p0 == '0), ctrl, lim_w);
      m1    = prep(raw1, 1'b0, ctrl, lim_w);
      k0    = branch_code(p0, bit_n, ctrl.poly_a, ctrl.poly_b);
      k1    = branch_code(p1, bit_n, ctrl.poly_a, ctrl.poly_b);
      s0    = {1'b0, m0} + (METRIC_BITS+1)'(k0[1] ^ ctrl.rx_a)
                         + (METRIC_BITS+1)'(k0[0] ^ ctrl.rx_b);
      s1    = {1'b0, m1} + (METRIC_BITS+1)'(k1[1] ^ ctrl.rx_a)
                         + (METRIC_BITS+1)'(k1[0] ^ ctrl.rx_b);
      c0    = s0[METRIC_BITS] ? METRIC_MAX : s0[METRIC_BITS-1:0];
      c1    = s1[METRIC_BITS] ? METRIC_MAX : s1[METRIC_BITS-1:0];
      if (ctrl.tail && bit_n) begin
         result.metric   = METRIC_MAX;
         result.survivor = p0;
      end else if (c1 < c0) begin
         result.metric   = c1;
         result.survivor = p1;
      end else begin
         result.metric   = c0;
         result.survivor = p0;
      end
   end
endmodule

// ----- rtl/core/viterbi_hard_decision_decoder_top.sv -----
// ----------------------------------------------------------------------------
// viterbi_hard_decision_decoder_top
// rate one half hard decision viterbi decoder, 64 states, traceback 32
//
//   channel   dir   transaction
//   req_ch    in    one received bit pair with frame flags
//   rsp_ch    out   one decoded bit with last flag and best metric
//   csr_ch    in    register write: index, data
//
// a pair is taken in idle, runs add-compare-select through the one shared unit
// (one state per cycle, metric ram read pipelined) and a decide state, then
// traceback when a bit is due, one survivor ram read per step, then the bits
// go out one per cycle.
// req_ch is ready only when idle; results wait on rsp_ch ready.
// reset is synchronous; survivor ram is never cleared, no clearing pass.
// ----------------------------------------------------------------------------
module viterbi_hard_decision_decoder_top (
   input logic       clock,
   input logic       reset,
   vhd_req_if.sink   req_ch,
   vhd_rsp_if.source rsp_ch,
   vhd_csr_if.sink   csr_ch
);
   import vhd_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_ACS, S_DECIDE, S_TB, S_EMIT} seq_state_type;

   localparam int SURV_AW = $clog2(SURV_DEPTH);
   localparam int MET_AW  = $clog2(MET_DEPTH);

   seq_state_type          state_ff;
   logic [POLY_W-1:0]      poly_a_ff, poly_b_ff;
   logic [LIMIT_W-1:0]     limit_ff;
   logic                   rx_a_ff, rx_b_ff, tail_ff, last_ff;
   logic                   fresh_ff, fresh_use_ff, norm_ff, bank_ff;
   logic [METRIC_BITS-1:0] norm_x_ff;
   logic [LIMIT_W-1:0]     norm_lim_ff;
   logic [COL_W-1:0]       hp_ff, tcol_ff;
   logic [STEP_W-1:0]      step_ff, t_ff, tailrun_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   pv_ff;
   logic [STATE_BITS-1:0]  pn_ff, min_h_ff;
   logic [METRIC_BITS-1:0] even_hold_ff, min_x_ff;
   logic [BEST_W-1:0]      best_ff;
   logic [TB_DEPTH:0]      dec_ff;
   logic [K_W-1:0]         j_ff, k_ff, khi_ff;

   logic                   req_acc, rs;
   logic [COL_W-1:0]       hp_base, hp_in;
   logic [STEP_W-1:0]      t_in, tr_base, tailrun_in;
   logic                   t_ge, emit_in;
   logic [K_W-1:0]         kfirst_in, khi_in;

   acs_ctrl_type           acs_ctrl;
   acs_result_type         acs_res;
   logic [MET_W-1:0]       met_rd;
   logic [STATE_BITS-1:0]  surv_rd;
   logic                   surv_rd_en;
   logic [SURV_AW-1:0]     surv_rd_addr;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = (state_ff == S_EMIT);
   assign rsp_ch.decoded_bit   = dec_ff[k_ff];
   assign rsp_ch.last_of_frame = last_ff && (k_ff == khi_ff);
   assign rsp_ch.best_metric   = best_ff;

   always_comb begin
      rs         = req_ch.frame_start || fresh_ff;
      hp_base    = rs ? '0 : hp_ff;
      hp_in      = (hp_base == COL_W'(HCOLS-1)) ? '0 : hp_base + 1'b1;
      t_in       = rs ? '0 : step_ff;
      tr_base    = rs ? '0 : tailrun_ff;
      tailrun_in = !req_ch.is_tail ? '0 :
                   (tr_base == STEP_MAX) ? tr_base : tr_base + 1'b1;
   end

   // bits due from this pair
   always_comb begin
      t_ge = (t_ff >= STEP_W'(TB_DEPTH-1));
      if (last_ff) begin
         kfirst_in = t_ge ? K_W'(1) : K_W'(TB_DEPTH) - t_ff[K_W-1:0];
         khi_in    = K_W'(TB_DEPTH) - tailrun_ff[K_W-1:0];
         emit_in   = (tailrun_ff <= STEP_W'(TB_DEPTH)) && (kfirst_in <= khi_in);
      end else begin
         kfirst_in = K_W'(1);
         khi_in    = K_W'(1);
         emit_in   = t_ge && (tailrun_ff <= STEP_W'(TB_DEPTH-1));
      end
   end

   always_comb begin
      acs_ctrl.fresh    = fresh_use_ff;
      acs_ctrl.norm     = norm_ff;
      acs_ctrl.norm_x   = norm_x_ff;
      acs_ctrl.norm_lim = norm_lim_ff;
      acs_ctrl.tail     = tail_ff;
      acs_ctrl.rx_a     = rx_a_ff;
      acs_ctrl.rx_b     = rx_b_ff;
      acs_ctrl.poly_a   = poly_a_ff;
      acs_ctrl.poly_b   = poly_b_ff;
   end

   vhd_acs u_acs (
      .state_n   (pn_ff),
      .pair_word (met_rd),
      .ctrl      (acs_ctrl),
      .result    (acs_res)
   );

   vhd_ram #(.WIDTH(MET_W), .DEPTH(MET_DEPTH)) u_metric_ram (
      .clock   (clock),
      .wr_en   (pv_ff && pn_ff[0]),
      .wr_addr ({~bank_ff, pn_ff[STATE_BITS-1:1]}),
      .wr_data ({acs_res.metric, even_hold_ff}),
      .rd_en   (state_ff == S_ACS),
      .rd_addr (MET_AW'({bank_ff, cnt_ff[PAIR_W-1:0]})),
      .rd_data (met_rd)
   );

   always_comb begin
      surv_rd_en   = (state_ff == S_DECIDE) || (state_ff == S_TB);
      surv_rd_addr = (state_ff == S_DECIDE) ? SURV_AW'({hp_ff, min_h_ff})
                                            : SURV_AW'({tcol_ff, surv_rd});
   end

   vhd_ram #(.WIDTH(STATE_BITS), .DEPTH(SURV_DEPTH)) u_survivor_ram (
      .clock   (clock),
      .wr_en   (pv_ff),
      .wr_addr (SURV_AW'({hp_ff, pn_ff})),
      .wr_data (acs_res.survivor),
      .rd_en   (surv_rd_en),
      .rd_addr (surv_rd_addr),
      .rd_data (surv_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         poly_a_ff    <= POLY_A_RESET;
         poly_b_ff    <= POLY_B_RESET;
         limit_ff     <= LIMIT_RESET;
         fresh_ff     <= 1'b1;
         fresh_use_ff <= 1'b1;
         norm_ff      <= 1'b0;
         bank_ff      <= 1'b0;
         hp_ff        <= '0;
         step_ff      <= '0;
         tailrun_ff   <= '0;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         j_ff         <= '0;
         k_ff         <= '0;
         khi_ff       <= '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_GEN_POLY_A:   poly_a_ff <= csr_ch.data[POLY_W-1:0];
               CSR_GEN_POLY_B:   poly_b_ff <= csr_ch.data[POLY_W-1:0];
               CSR_METRIC_LIMIT: limit_ff  <= csr_ch.data[LIMIT_W-1:0];
               default: ;
            endcase
         end

         // acs result stage
         if (pv_ff) begin
            even_hold_ff <= acs_res.metric;
            if ((pn_ff == '0) || (acs_res.metric < min_x_ff)) begin
               min_x_ff <= acs_res.metric;
               min_h_ff <= pn_ff;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  rx_a_ff      <= req_ch.rx_bit_a;
                  rx_b_ff      <= req_ch.rx_bit_b;
                  tail_ff      <= req_ch.is_tail;
                  last_ff      <= req_ch.frame_last;
                  fresh_use_ff <= rs;
                  hp_ff        <= hp_in;
                  t_ff         <= t_in;
                  step_ff      <= (t_in == STEP_MAX) ? t_in : t_in + 1'b1;
                  tailrun_ff   <= tailrun_in;
                  cnt_ff       <= '0;
                  state_ff     <= S_ACS;
               end
            end
            S_ACS: begin
               if (cnt_ff != CNT_W'(NSTATES)) begin
                  pv_ff  <= 1'b1;
                  pn_ff  <= cnt_ff[STATE_BITS-1:0];
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  pv_ff    <= 1'b0;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               bank_ff     <= ~bank_ff;
               fresh_ff    <= last_ff;
               norm_ff     <= t_ge && (min_x_ff > METRIC_BITS'(limit_ff));
               norm_x_ff   <= min_x_ff;
               norm_lim_ff <= limit_ff;
               best_ff     <= (min_x_ff > METRIC_BITS'(BEST_MAX)) ? BEST_MAX
                                                                  : BEST_W'(min_x_ff);
               dec_ff[TB_DEPTH] <= min_h_ff[STATE_BITS-1];
               j_ff        <= K_W'(TB_DEPTH-1);
               tcol_ff     <= (hp_ff == '0) ? COL_W'(HCOLS-1) : hp_ff - 1'b1;
               k_ff        <= kfirst_in;
               khi_ff      <= khi_in;
               state_ff    <= emit_in ? S_TB : S_IDLE;
            end
            S_TB: begin
               dec_ff[j_ff] <= surv_rd[STATE_BITS-1];
               tcol_ff      <= (tcol_ff == '0) ? COL_W'(HCOLS-1) : tcol_ff - 1'b1;
               j_ff         <= j_ff - 1'b1;
               if (j_ff == K_W'(1)) state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (rsp_ch.ready) begin
                  if (k_ff == khi_ff) state_ff <= S_IDLE;
                  else k_ff <= k_ff + 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ch.ready)
      else $error("request taken while busy");

   a_accept_starts_acs: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == S_ACS) && (cnt_ff == '0))
      else $error("accepted pair did not start add-compare-select");

   a_emit_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (k_ff <= khi_ff) && (k_ff != '0))
      else $error("emit index out of range");

   a_traceback_step_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TB) |-> (j_ff != '0) && (tcol_ff < COL_W'(HCOLS)))
      else $error("traceback step out of range");

endmodule

// ----- bench/viterbi_hard_decision_decoder_top_test.sv -----
// ----------------------------------------------------------------------------
// viterbi_hard_decision_decoder_top_test
// self-checking bench for the rate one half hard decision viterbi decoder:
// a table of pairs checked against listed results, then encoded frames with
// random bit errors, broken frames and random pairs under several register
// settings and idle patterns, checked against a trellis model in the bench
// ----------------------------------------------------------------------------
module viterbi_hard_decision_decoder_top_test;
   import vhd_pkg::*;

   localparam int NST     = 64;
   localparam int DEPTH   = 32;
   localparam int COLS    = DEPTH + 1;
   localparam int MET_TOP = 65535;

   typedef enum int {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idle_mode_type;

   typedef struct packed {
      logic              bit_out;
      logic              last;
      logic [BEST_W-1:0] best;
   } decoded_type;

   typedef struct packed {
      logic a, b, start, tail, last;
   } pair_type;

   typedef struct {
      pair_type    pair;
      bit          typed;
      int          n_typed;
      decoded_type typed_bit;
   } row_type;

   logic clock = 0;
   logic reset = 1;

   vhd_req_if req_ch();
   vhd_rsp_if rsp_ch();
   vhd_csr_if csr_ch();

   viterbi_hard_decision_decoder_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   // decoder model state
   logic [POLY_W-1:0]  poly_a, poly_b;
   logic [LIMIT_W-1:0] limit;
   int unsigned        metric[NST];
   logic [5:0]         survivor[NST][COLS];
   int unsigned        steps, col_ptr, tail_len;

   decoded_type pending_bits[$];
   int          errors = 0;
   int          send_idle_pct = 0, recv_idle_pct = 0, hold_cycles = 0;
   bit          use_table = 0;
   int          table_n = 0;
   decoded_type table_bit;

   initial forever #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [1:0] code_pair(logic [5:0] st, logic in_bit);
      logic [6:0] sr;
      sr = {st[0], st[1], st[2], st[3], st[4], st[5], in_bit};
      return {^(sr & poly_a), ^(sr & poly_b)};
   endfunction

   function automatic void trellis_restart();
      for (int n = 0; n < NST; n++) metric[n] = MET_TOP;
      metric[0] = 0;
      steps = 0;
      col_ptr = 0;
      tail_len = 0;
   endfunction

   function automatic void decode_pair(pair_type p);
      int unsigned nxt[NST];
      int unsigned c0, c1, x, best;
      logic [5:0]  p0, p1, h;
      logic [1:0]  k0, k1;
      logic [5:0]  seq[COLS];
      logic [5:0]  s;
      logic        in_bit;
      int          t, lo, hi, first, k;
      decoded_type d;
      if (p.start) trellis_restart();
      col_ptr = (col_ptr == COLS - 1) ? 0 : col_ptr + 1;
      for (int n = 0; n < NST; n++) begin
         in_bit = n[5];
         p0 = 6'((n << 1) & 63);
         p1 = p0 | 6'd1;
         if (p.tail && in_bit) begin
            nxt[n] = MET_TOP;
            survivor[n][col_ptr] = p0;
         end else begin
            k0 = code_pair(p0, in_bit);
            k1 = code_pair(p1, in_bit);
            c0 = metric[p0] + (k0[1] ^ p.a) + (k0[0] ^ p.b);
            c1 = metric[p1] + (k1[1] ^ p.a) + (k1[0] ^ p.b);
            if (c0 > MET_TOP) c0 = MET_TOP;
            if (c1 > MET_TOP) c1 = MET_TOP;
            nxt[n] = (c1 < c0) ? c1 : c0;
            survivor[n][col_ptr] = (c1 < c0) ? p1 : p0;
         end
      end
      metric = nxt;
      if (p.tail) begin
         if (tail_len < 65535) tail_len++;
      end else tail_len = 0;
      t = steps;
      x = metric[0];
      h = 0;
      for (int n = 1; n < NST; n++)
         if (metric[n] < x) begin
            x = metric[n];
            h = 6'(n);
         end
      best = (x > 32767) ? 32767 : x;
      if (t >= DEPTH - 1 && x > limit)
         for (int n = 0; n < NST; n++)
            metric[n] = (metric[n] - x > limit) ? limit : metric[n] - x;
      lo = t - DEPTH + 1;
      hi = t - int'(tail_len);
      if (p.last) first = (lo < 0) ? 0 : lo;
      else if (t >= DEPTH - 1 && lo <= hi) begin
         first = lo;
         hi = lo;
      end else begin
         first = 1;
         hi = 0;
      end
      if (first <= hi) begin
         seq[DEPTH] = h;
         for (int j = DEPTH; j > 0; j--)
            seq[j-1] = survivor[seq[j]][(col_ptr + j + 1) % COLS];
         for (int i = first; i <= hi; i++) begin
            k = i - (t - DEPTH);
            s = (k >= 0 && k <= DEPTH) ? seq[k] : 6'd0;
            d.bit_out = s[5];
            d.last = p.last && (i == hi);
            d.best = BEST_W'(best);
            if (!use_table) pending_bits.push_back(d);
         end
      end
      if (use_table)
         for (int i = 0; i < table_n; i++) pending_bits.push_back(table_bit);
      if (steps < 65535) steps++;
      if (p.last) trellis_restart();
   endfunction

   // request monitor feeds the model
   always @(posedge clock)
      if (!reset && req_ch.valid && req_ch.ready)
         decode_pair({req_ch.rx_bit_a, req_ch.rx_bit_b, req_ch.frame_start,
                      req_ch.is_tail, req_ch.frame_last});

   // result checker
   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         decoded_type want;
         if (pending_bits.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transaction: bit %0d last %0d best %0d",
                                       rsp_ch.decoded_bit, rsp_ch.last_of_frame,
                                       rsp_ch.best_metric);
         end else begin
            want = pending_bits.pop_front();
            if (want.bit_out !== rsp_ch.decoded_bit || want.last !== rsp_ch.last_of_frame
                || want.best !== rsp_ch.best_metric) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected bit %0d last %0d best %0d, got %0d %0d %0d",
                           want.bit_out, want.last, want.best, rsp_ch.decoded_bit,
                           rsp_ch.last_of_frame, rsp_ch.best_metric);
            end
         end
      end

   // receiver with random stalls and long hold-off
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 0;
            hold_cycles--;
         end else rsp_ch.ready <= ($urandom % 100) >= recv_idle_pct;
      end
   end

   task automatic set_idle(idle_mode_type m);
      case (m)
         IDLE_SENDER_LIGHT: begin
            send_idle_pct = 16;
            recv_idle_pct = 48;
         end
         IDLE_SENDER_HEAVY: begin
            send_idle_pct = 48;
            recv_idle_pct = 16;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic send_pair(pair_type p);
      if (($urandom % 100) < send_idle_pct) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid       <= 1;
      req_ch.rx_bit_a    <= p.a;
      req_ch.rx_bit_b    <= p.b;
      req_ch.frame_start <= p.start;
      req_ch.is_tail     <= p.tail;
      req_ch.frame_last  <= p.last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic settle();
      req_ch.valid <= 0;
      while (pending_bits.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 0;
      if (idx == CSR_GEN_POLY_A) poly_a = POLY_W'(value);
      else if (idx == CSR_GEN_POLY_B) poly_b = POLY_W'(value);
      else if (idx == CSR_METRIC_LIMIT) limit = LIMIT_W'(value);
      @(posedge clock);
   endtask

   // encoded frame with bit errors; broken frames may lose start, tail or last
   task automatic send_frame(int msg_len, bit broken, ref int sent);
      logic [5:0] st;
      logic [1:0] c;
      logic       in_bit;
      pair_type   p;
      int         n_tail, err_pct;
      st = 0;
      n_tail = broken ? $urandom_range(0, 6) : 6;
      err_pct = $urandom_range(0, 12);
      for (int i = 0; i < msg_len + n_tail; i++) begin
         in_bit = (i < msg_len) ? 1'($urandom) : 1'b0;
         c = code_pair(st, in_bit);
         st = {in_bit, st[5:1]};
         p.a = c[1] ^ (($urandom % 100) < err_pct);
         p.b = c[0] ^ (($urandom % 100) < err_pct);
         p.start = (i == 0);
         p.tail = (i >= msg_len);
         p.last = (i == msg_len + n_tail - 1);
         if (broken && ($urandom % 4 == 0)) p = pair_type'(5'($urandom));
         if (broken && p.last && ($urandom % 2)) p.last = 0;
         send_pair(p);
         sent++;
      end
   endtask

   row_type rows[16] = '{
      '{pair_type'(5'b00101), 1, 1, decoded_type'({1'b0, 1'b1, 15'd0})},
      '{pair_type'(5'b11101), 1, 1, decoded_type'({1'b1, 1'b1, 15'd0})},
      '{pair_type'(5'b00111), 1, 0, decoded_type'(0)},
      '{pair_type'(5'b10100), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b01010), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b11000), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b00011), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b10001), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b01001), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b00110), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b11010), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b10000), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b01010), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b11001), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b11110), 0, 0, decoded_type'(0)},
      '{pair_type'(5'b00011), 0, 0, decoded_type'(0)}
   };

   int unsigned settings[6][3] = '{
      '{121, 91, 16384}, '{127, 127, 32767}, '{0, 0, 1},
      '{79, 109, 0}, '{1, 64, 3}, '{121, 91, 40}
   };

   initial begin
      int sent;
      pair_type p;
      req_ch.valid = 0;
      req_ch.rx_bit_a = 0;
      req_ch.rx_bit_b = 0;
      req_ch.frame_start = 0;
      req_ch.is_tail = 0;
      req_ch.frame_last = 0;
      csr_ch.valid = 0;
      csr_ch.index = CSR_GEN_POLY_A;
      csr_ch.data = 0;
      poly_a = POLY_A_RESET;
      poly_b = POLY_B_RESET;
      limit = LIMIT_RESET;
      for (int n = 0; n < NST; n++)
         for (int c = 0; c < COLS; c++) survivor[n][c] = 0;
      trellis_restart();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      set_idle(IDLE_SENDER_LIGHT);
      foreach (rows[i]) begin
         use_table = rows[i].typed;
         table_n = rows[i].n_typed;
         table_bit = rows[i].typed_bit;
         send_pair(rows[i].pair);
         req_ch.valid <= 0;
         @(posedge clock);
      end
      settle();
      use_table = 0;

      for (int s = 0; s < 6; s++) begin
         write_reg(CSR_GEN_POLY_A, settings[s][0]);
         write_reg(CSR_GEN_POLY_B, settings[s][1]);
         write_reg(CSR_METRIC_LIMIT, settings[s][2]);
         set_idle(idle_mode_type'(s % 3));
         if (s == 2) hold_cycles = 3000;
         sent = 0;
         while (sent < 62) begin
            case ($urandom % 10)
               0, 1, 2, 3, 4, 5, 6:
                  send_frame(($urandom % 8 == 0) ? $urandom_range(33, 60)
                                                 : $urandom_range(1, 20), 0, sent);
               7, 8: send_frame($urandom_range(1, 20), 1, sent);
               default:
                  repeat ($urandom_range(1, 8)) begin
                     p = pair_type'(5'($urandom));
                     send_pair(p);
                     sent++;
                  end
            endcase
         end
         settle();
      end

      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
